/* design/fps_pkg.sv */
// shared types and constants of the five-point sharpening stencil
// used by every module of the block but fps_ram; no dependencies
package fps_pkg;

    // geometry and number formats
    localparam int MAX_WIDTH       = 1024;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int PIXEL_BITS      = 16;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_FRAC       = 12;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int ROW_BITS        = HEIGHT_REG_BITS + 1;

    // datapath widths
    localparam int SUM_BITS  = PIXEL_BITS + 2;
    localparam int PC_BITS   = PIXEL_BITS + GAIN_BITS;
    localparam int PE_BITS   = SUM_BITS + GAIN_BITS;
    localparam int ACC_BITS  = PE_BITS + 1;
    localparam int RES_BITS  = ACC_BITS - GAIN_FRAC;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_CENTER_GAIN  = 2'd2,
        CFG_EDGE_GAIN    = 2'd3
    } t_cfg_idx;

    // stream mode codes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // reset values of the registers
    localparam logic [WIDTH_REG_BITS-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic signed [GAIN_BITS-1:0] RST_CENTER_GAIN = 16'sd20480;
    localparam logic signed [GAIN_BITS-1:0] RST_EDGE_GAIN   = -16'sd4096;

    // one classified stencil step, front to back
    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pixel;
        logic [COL_BITS-1:0]          col;
        logic                         produce;
        logic                         up_edge;
        logic                         down_edge;
        logic                         left_edge;
        logic                         right_edge;
        logic                         eof;
    } t_item;

endpackage

/* design/fps_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// read-first when both ports hit one address; no dependencies
module fps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/fps_queue.sv */
// small fifo of classified steps between front and back
// depends on fps_pkg
module fps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fps_pkg::t_item i_item,
    input  logic           i_pop,
    output fps_pkg::t_item o_head,
    output logic           o_empty,
    output logic           o_full
);
    import fps_pkg::*;

    t_item                r_entry [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr, n_wptr;
    logic [QPTR_BITS-1:0] r_rptr, n_rptr;
    logic [QPTR_BITS:0]   r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_head  = r_entry[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_item;
        end
    end

endmodule

/* design/fps_front.sv */
// front end: accepts stream words, drops early flushes, tracks raster position
// and output position, and tags each step with its edge flags; depends on fps_pkg
module fps_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_restart,
    input  logic [fps_pkg::WIDTH_REG_BITS-1:0]    i_frame_width,
    input  logic [fps_pkg::HEIGHT_REG_BITS-1:0]   i_frame_height,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_mode,
    input  logic signed [fps_pkg::PIXEL_BITS-1:0] i_pixel,
    input  logic                                  i_full,
    output logic                                  o_push,
    output fps_pkg::t_item                        o_item
);
    import fps_pkg::*;

    logic [COL_BITS-1:0]        r_col, n_col;
    logic [ROW_BITS-1:0]        r_row, n_row;
    logic [COL_BITS-1:0]        r_ox, n_ox;
    logic [HEIGHT_REG_BITS-1:0] r_oy, n_oy;

    logic [WIDTH_REG_BITS-1:0]  w_eff;
    logic [HEIGHT_REG_BITS-1:0] h_eff;
    logic [COL_BITS-1:0]        w_last;
    logic [HEIGHT_REG_BITS-1:0] h_last;
    logic                       draining;
    logic                       accept;
    logic                       step;
    logic                       produce;
    logic                       up_edge, down_edge, left_edge, right_edge;
    logic                       eof;

    // effective geometry: width clamped to 1..MAX_WIDTH, height at least 1
    always_comb begin
        w_eff = i_frame_width;
        if (i_frame_width == '0) begin
            w_eff = WIDTH_REG_BITS'(1);
        end else if (i_frame_width > WIDTH_REG_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_REG_BITS'(MAX_WIDTH);
        end
        h_eff = (i_frame_height == '0) ? HEIGHT_REG_BITS'(1) : i_frame_height;
    end

    assign w_last = COL_BITS'(w_eff - 1'b1);
    assign h_last = h_eff - 1'b1;

    // classification of the incoming word
    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign draining = (r_row >= ROW_BITS'(h_eff));
    assign step     = accept && (draining || (i_mode == MODE_PIXEL));

    // a result is due once one row and one pixel have gone in
    assign produce    = (r_row > ROW_BITS'(1)) || ((r_row == ROW_BITS'(1)) && (r_col != '0));
    assign up_edge    = (r_oy == '0);
    assign down_edge  = (r_oy == h_last);
    assign left_edge  = (r_ox == '0);
    assign right_edge = (r_ox == w_last);
    assign eof        = produce && down_edge && right_edge;

    assign o_push            = step;
    assign o_item.pixel      = draining ? '0 : i_pixel;
    assign o_item.col        = r_col;
    assign o_item.produce    = produce;
    assign o_item.up_edge    = up_edge;
    assign o_item.down_edge  = down_edge;
    assign o_item.left_edge  = left_edge;
    assign o_item.right_edge = right_edge;
    assign o_item.eof        = eof;

    // raster and output position counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ox  = r_ox;
        n_oy  = r_oy;
        if (i_restart || (step && eof)) begin
            n_col = '0;
            n_row = '0;
            n_ox  = '0;
            n_oy  = '0;
        end else if (step) begin
            if (produce) begin
                if (right_edge) begin
                    n_ox = '0;
                    n_oy = r_oy + 1'b1;
                end else begin
                    n_ox = r_ox + 1'b1;
                end
            end
            if (r_col == w_last) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
        end
    end

endmodule

/* design/fps_back.sv */
// back end: line buffers, tap window, multiply, round and saturate, output register
// depends on fps_pkg and fps_ram
module fps_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_restart,
    input  logic signed [fps_pkg::GAIN_BITS-1:0]  i_center_gain,
    input  logic signed [fps_pkg::GAIN_BITS-1:0]  i_edge_gain,
    input  fps_pkg::t_item                        i_head,
    input  logic                                  i_empty,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [fps_pkg::PIXEL_BITS-1:0] o_pixel,
    output logic                                  o_sat,
    output logic                                  o_eof
);
    import fps_pkg::*;

    localparam logic signed [ACC_BITS-1:0] ROUND = ACC_BITS'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

    logic                          adv;
    logic                          pop;

    // line buffer ports
    logic [PIXEL_BITS-1:0]         mid_rd, up_rd;
    logic                          up_we;

    // stage one: buffer read data and window
    logic                          r_s1_valid;
    t_item                         r_s1;
    logic                          r_fwd;
    logic signed [PIXEL_BITS-1:0]  r_fwd_val;
    logic signed [PIXEL_BITS-1:0]  mid, above;
    logic signed [PIXEL_BITS-1:0]  r_left, r_up, r_ctr, r_down;

    logic signed [PIXEL_BITS-1:0]  t_up, t_down, t_left, t_right;
    logic signed [SUM_BITS-1:0]    sum4;

    // stage two: multiplier operands
    logic                          r_s2_valid;
    logic signed [PIXEL_BITS-1:0]  r_s2_ctr;
    logic signed [SUM_BITS-1:0]    r_s2_sum;
    logic                          r_s2_eof;

    // stage three: products
    logic                          r_s3_valid;
    logic signed [PC_BITS-1:0]     r_pc;
    logic signed [PE_BITS-1:0]     r_pe;
    logic                          r_s3_eof;

    logic signed [ACC_BITS-1:0]    acc;
    logic [RES_BITS-1:0]           res;
    logic [RES_BITS-PIXEL_BITS:0]  res_top;
    logic                          sat;
    logic signed [PIXEL_BITS-1:0]  clipped;

    // output register
    logic                          r_out_valid;
    logic signed [PIXEL_BITS-1:0]  r_out_pixel;
    logic                          r_out_sat;
    logic                          r_out_eof;

    // whole back pipe moves unless the output word is held
    assign adv   = !r_out_valid || i_ready;
    assign pop   = !i_empty && adv;
    assign o_pop = pop;
    assign up_we = r_s1_valid && adv;

    // middle row: read old and write new sample at the same column
    fps_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (pop),
        .i_waddr (i_head.col),
        .i_wdata (i_head.pixel),
        .i_re    (pop),
        .i_raddr (i_head.col),
        .o_rdata (mid_rd)
    );

    // upper row: gets the middle sample once it has been read
    fps_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_up_ram (
        .i_clk   (i_clk),
        .i_we    (up_we),
        .i_waddr (r_s1.col),
        .i_wdata (mid),
        .i_re    (pop),
        .i_raddr (i_head.col),
        .o_rdata (up_rd)
    );

    // one-pixel-wide frames read the upper entry in the cycle it is written
    assign mid   = $signed(mid_rd);
    assign above = r_fwd ? r_fwd_val : $signed(up_rd);

    // edge taps fall back to the centre pixel
    always_comb begin
        t_up    = r_s1.up_edge    ? r_ctr : r_up;
        t_down  = r_s1.down_edge  ? r_ctr : r_down;
        t_left  = r_s1.left_edge  ? r_ctr : r_left;
        t_right = r_s1.right_edge ? r_ctr : mid;
        sum4    = SUM_BITS'(t_up) + SUM_BITS'(t_down) + SUM_BITS'(t_left)
                + SUM_BITS'(t_right);
    end

    // stage one control and bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= pop;
            r_fwd      <= pop && r_s1_valid && (r_s1.col == i_head.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1      <= i_head;
            r_fwd_val <= mid;
        end
    end

    // tap window: shift per step, clear at frame end and on restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_left <= '0;
            r_up   <= '0;
            r_ctr  <= '0;
            r_down <= '0;
        end else if (adv && r_s1_valid) begin
            if (r_s1.eof) begin
                r_left <= '0;
                r_up   <= '0;
                r_ctr  <= '0;
                r_down <= '0;
            end else begin
                r_left <= r_ctr;
                r_up   <= above;
                r_ctr  <= mid;
                r_down <= r_s1.pixel;
            end
        end
    end

    // arithmetic pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid  <= r_s1_valid && r_s1.produce;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // round half up, shift down, clip to the pixel range
    assign acc     = ACC_BITS'(r_pc) + ACC_BITS'(r_pe) + ROUND;
    assign res     = acc[ACC_BITS-1:GAIN_FRAC];
    assign res_top = res[RES_BITS-1:PIXEL_BITS-1];
    assign sat     = !((&res_top) || !(|res_top));
    assign clipped = sat ? (res[RES_BITS-1] ? PIX_MIN : PIX_MAX)
                         : $signed(res[PIXEL_BITS-1:0]);

    // arithmetic pipe payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ctr    <= r_ctr;
            r_s2_sum    <= sum4;
            r_s2_eof    <= r_s1.eof;
            r_pc        <= PC_BITS'(r_s2_ctr) * PC_BITS'(i_center_gain);
            r_pe        <= PE_BITS'(r_s2_sum) * PE_BITS'(i_edge_gain);
            r_s3_eof    <= r_s2_eof;
            r_out_pixel <= clipped;
            r_out_sat   <= sat;
            r_out_eof   <= r_s3_eof;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pixel;
    assign o_sat   = r_out_sat;
    assign o_eof   = r_out_eof;

endmodule

/* design/five_point_sharpen_stencil_top.sv */
// top level of the five-point sharpening stencil: configuration registers,
// front end, step queue and back end; depends on fps_pkg, fps_front, fps_queue, fps_back
//
// Pixels enter in raster order, one word per clock at full rate while the step queue
// has room. Each position gets centre*center_gain + (up+down+left+right)*edge_gain
// in Q4.12, rounded half up, shifted right by 12 and clipped to 16 bits (tuser flags
// a clip). Neighbours off the image take the centre value. The result for a position
// leaves after the pixel one row and one pixel later has gone in, then passes through
// the buffer read, operand, multiply and round stages. After the last pixel of a frame
// send frame_width+1 flush words to drain it; tlast marks the last result. A flush
// word while pixels are still due is taken and dropped. Two 1024 x 16 line buffers
// hold the previous rows; they need no clearing after reset. Writing frame_width or
// frame_height restarts the frame; write registers only while the block is idle.
module five_point_sharpen_stencil_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [fps_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [fps_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [fps_pkg::PIXEL_BITS-1:0]        s_axis_tdata,  // [15:0] pixel
    input  logic                                  s_axis_tuser,  // [0] mode
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [fps_pkg::PIXEL_BITS-1:0]        m_axis_tdata,  // [15:0] out_pixel
    output logic                                  m_axis_tuser,  // [0] saturated
    output logic                                  m_axis_tlast   // end_of_frame
);
    import fps_pkg::*;

    logic [WIDTH_REG_BITS-1:0]    r_frame_width;
    logic [HEIGHT_REG_BITS-1:0]   r_frame_height;
    logic signed [GAIN_BITS-1:0]  r_center_gain;
    logic signed [GAIN_BITS-1:0]  r_edge_gain;
    logic                         restart;

    logic                         push, pop, q_empty, q_full;
    t_item                        push_item, head_item;
    logic signed [PIXEL_BITS-1:0] out_pixel;

    // geometry writes restart the frame
    assign restart = i_cfg_we && ((t_cfg_idx'(i_cfg_idx) == CFG_FRAME_WIDTH)
                               || (t_cfg_idx'(i_cfg_idx) == CFG_FRAME_HEIGHT));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_center_gain  <= RST_CENTER_GAIN;
            r_edge_gain    <= RST_EDGE_GAIN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[WIDTH_REG_BITS-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[HEIGHT_REG_BITS-1:0];
                end
                CFG_CENTER_GAIN: begin
                    r_center_gain <= $signed(i_cfg_data[GAIN_BITS-1:0]);
                end
                CFG_EDGE_GAIN: begin
                    r_edge_gain <= $signed(i_cfg_data[GAIN_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // accept and classify
    fps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (restart),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_mode         (s_axis_tuser),
        .i_pixel        ($signed(s_axis_tdata)),
        .i_full         (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    // decoupling queue
    fps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // filter datapath
    fps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (restart),
        .i_center_gain (r_center_gain),
        .i_edge_gain   (r_edge_gain),
        .i_head        (head_item),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_pixel       (out_pixel),
        .o_sat         (m_axis_tuser),
        .o_eof         (m_axis_tlast)
    );

    assign m_axis_tdata = out_pixel;

endmodule
